[rtl/core/cau_pkg.sv]
`default_nettype none

package cau_pkg;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MATH_ERR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Default format: signed Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Control that travels with each transaction down the pipeline
    typedef struct packed {
        logic valid;   // transaction present in this stage
        logic div;     // divide operation
        logic dz;      // divisor is exactly zero
        logic neg_re;  // sign of real part
        logic neg_im;  // sign of imaginary part
        logic big_re;  // real quotient does not fit DATA_WIDTH bits
        logic big_im;  // imaginary quotient does not fit DATA_WIDTH bits
    } t_ctl;

endpackage

`default_nettype wire

[rtl/core/cau_front.sv]
`default_nettype none

module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [1:0]                    i_operation,
    input  wire logic signed [DATA_WIDTH-1:0]  i_left_re,
    input  wire logic signed [DATA_WIDTH-1:0]  i_left_im,
    input  wire logic signed [DATA_WIDTH-1:0]  i_right_re,
    input  wire logic signed [DATA_WIDTH-1:0]  i_right_im,
    output cau_pkg::t_ctl                      o_ctl,
    output logic [1:0][2*DATA_WIDTH:0]         o_rem,
    output logic [1:0][DATA_WIDTH-1:0]         o_nlo,
    output logic [2*DATA_WIDTH:0]              o_dv
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int RW = 2 * W + 1;
    localparam int NW = 2 * W + FRAC_BITS + 2;
    localparam logic [RW-1:0] HALF = (RW'(1) << FRAC_BITS) >> 1;

    // Stage 1: capture operands
    logic                r1_valid;
    logic [1:0]          r1_op;
    logic signed [W-1:0] r1_a, r1_b, r1_c, r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_op <= i_operation;
        r1_a  <= i_left_re;
        r1_b  <= i_left_im;
        r1_c  <= i_right_re;
        r1_d  <= i_right_im;
    end

    // Stage 2: partial products and part-wise add or subtract
    logic signed [PW-1:0] n_ac, n_bd, n_ad, n_bc, n_cc, n_dd;
    logic signed [W:0]    n_sre, n_sim;
    logic signed [PW-1:0] r2_ac, r2_bd, r2_ad, r2_bc, r2_cc, r2_dd;
    logic signed [W:0]    r2_sre, r2_sim;
    logic                 r2_valid;
    logic [1:0]           r2_op;

    always_comb begin
        n_ac = r1_a * r1_c;
        n_bd = r1_b * r1_d;
        n_ad = r1_a * r1_d;
        n_bc = r1_b * r1_c;
        n_cc = r1_c * r1_c;
        n_dd = r1_d * r1_d;
        if (r1_op == cau_pkg::OP_SUB) begin
            n_sre = $signed({r1_a[W-1], r1_a}) - $signed({r1_c[W-1], r1_c});
            n_sim = $signed({r1_b[W-1], r1_b}) - $signed({r1_d[W-1], r1_d});
        end else begin
            n_sre = $signed({r1_a[W-1], r1_a}) + $signed({r1_c[W-1], r1_c});
            n_sim = $signed({r1_b[W-1], r1_b}) + $signed({r1_d[W-1], r1_d});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_op  <= r1_op;
        r2_ac  <= n_ac;
        r2_bd  <= n_bd;
        r2_ad  <= n_ad;
        r2_bc  <= n_bc;
        r2_cc  <= n_cc;
        r2_dd  <= n_dd;
        r2_sre <= n_sre;
        r2_sim <= n_sim;
    end

    // Stage 3: combine products into exact signed parts and the divisor norm
    logic signed [PW:0] n_xre, n_xim;
    logic [PW-1:0]      n_den;
    logic signed [PW:0] r3_xre, r3_xim;
    logic [PW-1:0]      r3_den;
    logic               r3_valid;
    logic [1:0]         r3_op;

    always_comb begin
        n_den = PW'(r2_cc + r2_dd);
        case (r2_op)
            cau_pkg::OP_MUL: begin
                n_xre = $signed({r2_ac[PW-1], r2_ac}) - $signed({r2_bd[PW-1], r2_bd});
                n_xim = $signed({r2_ad[PW-1], r2_ad}) + $signed({r2_bc[PW-1], r2_bc});
            end
            cau_pkg::OP_DIV: begin
                n_xre = $signed({r2_ac[PW-1], r2_ac}) + $signed({r2_bd[PW-1], r2_bd});
                n_xim = $signed({r2_bc[PW-1], r2_bc}) - $signed({r2_ad[PW-1], r2_ad});
            end
            default: begin
                n_xre = (PW+1)'(r2_sre);
                n_xim = (PW+1)'(r2_sim);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_op  <= r2_op;
        r3_xre <= n_xre;
        r3_xim <= n_xim;
        r3_den <= n_den;
    end

    // Stage 4: split into sign and magnitude, flag a zero divisor
    logic [PW:0]   n_are, n_aim;
    logic [PW-1:0] r4_mre, r4_mim, r4_den;
    logic          r4_nre, r4_nim, r4_dz, r4_valid;
    logic [1:0]    r4_op;

    always_comb begin
        n_are = r3_xre[PW] ? PW'(-r3_xre) : r3_xre;
        n_aim = r3_xim[PW] ? PW'(-r3_xim) : r3_xim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_op  <= r3_op;
        r4_nre <= r3_xre[PW];
        r4_nim <= r3_xim[PW];
        r4_mre <= n_are[PW-1:0];
        r4_mim <= n_aim[PW-1:0];
        r4_den <= r3_den;
        r4_dz  <= (r3_den == '0);
    end

    // Stage 5: round products, build dividend and doubled divisor
    logic [RW-1:0] n_vre, n_vim;
    logic [NW-1:0] n_nre, n_nim;
    logic [RW-1:0] r5_vre, r5_vim, r5_dv;
    logic [NW-1:0] r5_nre, r5_nim;
    logic          r5_nre_s, r5_nim_s, r5_dz, r5_valid;
    logic [1:0]    r5_op;

    always_comb begin
        if (r4_op == cau_pkg::OP_MUL) begin
            n_vre = (RW'(r4_mre) + HALF) >> FRAC_BITS;
            n_vim = (RW'(r4_mim) + HALF) >> FRAC_BITS;
        end else begin
            n_vre = RW'(r4_mre);
            n_vim = RW'(r4_mim);
        end
        n_nre = (NW'(r4_mre) << (FRAC_BITS + 1)) + NW'(r4_den);
        n_nim = (NW'(r4_mim) << (FRAC_BITS + 1)) + NW'(r4_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_op    <= r4_op;
        r5_nre_s <= r4_nre;
        r5_nim_s <= r4_nim;
        r5_dz    <= r4_dz;
        r5_vre   <= n_vre;
        r5_vim   <= n_vim;
        r5_nre   <= n_nre;
        r5_nim   <= n_nim;
        r5_dv    <= {r4_den, 1'b0};
    end

    // Stage 6: seed the division row; a top part at or above the divisor
    // means the quotient needs more than DATA_WIDTH bits
    logic [NW-1:0]  n_hre, n_him;
    logic           n_div;
    cau_pkg::t_ctl  r6_ctl;
    logic [1:0][RW-1:0] r6_rem;
    logic [1:0][W-1:0]  r6_nlo;
    logic [RW-1:0]  r6_dv;

    always_comb begin
        n_hre = r5_nre >> W;
        n_him = r5_nim >> W;
        n_div = (r5_op == cau_pkg::OP_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl.valid <= 1'b0;
        end else begin
            r6_ctl.valid <= r5_valid;
        end
        r6_ctl.div    <= n_div;
        r6_ctl.dz     <= n_div && r5_dz;
        r6_ctl.neg_re <= r5_nre_s;
        r6_ctl.neg_im <= r5_nim_s;
        r6_ctl.big_re <= (n_hre >= NW'(r5_dv));
        r6_ctl.big_im <= (n_him >= NW'(r5_dv));
        // non-divide results ride in the remainder field
        r6_rem[0]     <= n_div ? n_hre[RW-1:0] : r5_vre;
        r6_rem[1]     <= n_div ? n_him[RW-1:0] : r5_vim;
        r6_nlo[0]     <= r5_nre[W-1:0];
        r6_nlo[1]     <= r5_nim[W-1:0];
        r6_dv         <= r5_dv;
    end

    assign o_ctl = r6_ctl;
    assign o_rem = r6_rem;
    assign o_nlo = r6_nlo;
    assign o_dv  = r6_dv;

endmodule

`default_nettype wire

[rtl/core/cau_cell.sv]
`default_nettype none

module cau_cell #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cau_pkg::t_ctl                 i_ctl,
    input  wire logic [1:0][2*DATA_WIDTH:0]    i_rem,
    input  wire logic [1:0][DATA_WIDTH-1:0]    i_nlo,
    input  wire logic [1:0][DATA_WIDTH-1:0]    i_q,
    input  wire logic [2*DATA_WIDTH:0]         i_dv,
    output cau_pkg::t_ctl                      o_ctl,
    output logic [1:0][2*DATA_WIDTH:0]         o_rem,
    output logic [1:0][DATA_WIDTH-1:0]         o_nlo,
    output logic [1:0][DATA_WIDTH-1:0]         o_q,
    output logic [2*DATA_WIDTH:0]              o_dv
);

    localparam int W  = DATA_WIDTH;
    localparam int RW = 2 * W + 1;

    logic [1:0][RW-1:0] n_rem;
    logic [1:0][W-1:0]  n_nlo, n_q;
    logic [1:0][RW:0]   n_t, n_diff;
    logic [1:0]         n_ge;
    logic               n_step;

    // One restoring-division step per part: shift in a dividend bit,
    // subtract the divisor when it fits, shift the quotient bit in
    always_comb begin
        n_step = i_ctl.div && !i_ctl.dz;
        for (int p = 0; p < 2; p++) begin
            n_t[p]    = {i_rem[p], i_nlo[p][W-1]};
            n_diff[p] = n_t[p] - {1'b0, i_dv};
            n_ge[p]   = (n_t[p] >= {1'b0, i_dv});
            if (n_step) begin
                n_rem[p] = n_ge[p] ? n_diff[p][RW-1:0] : n_t[p][RW-1:0];
                n_nlo[p] = i_nlo[p] << 1;
                n_q[p]   = {i_q[p][W-2:0], n_ge[p]};
            end else begin
                n_rem[p] = i_rem[p];
                n_nlo[p] = i_nlo[p];
                n_q[p]   = i_q[p];
            end
        end
    end

    // Advance to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else begin
            o_ctl.valid <= i_ctl.valid;
        end
        o_ctl.div    <= i_ctl.div;
        o_ctl.dz     <= i_ctl.dz;
        o_ctl.neg_re <= i_ctl.neg_re;
        o_ctl.neg_im <= i_ctl.neg_im;
        o_ctl.big_re <= i_ctl.big_re;
        o_ctl.big_im <= i_ctl.big_im;
        o_rem        <= n_rem;
        o_nlo        <= n_nlo;
        o_q          <= n_q;
        o_dv         <= i_dv;
    end

endmodule

`default_nettype wire

[rtl/core/cau_back.sv]
`default_nettype none

module cau_back #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cau_pkg::t_ctl                 i_ctl,
    input  wire logic [1:0][2*DATA_WIDTH:0]    i_rem,
    input  wire logic [1:0][DATA_WIDTH-1:0]    i_q,
    output logic                               o_done,
    output logic signed [DATA_WIDTH-1:0]       o_result_re,
    output logic signed [DATA_WIDTH-1:0]       o_result_im,
    output logic [1:0]                         o_status
);

    localparam int W  = DATA_WIDTH;
    localparam int RW = 2 * W + 1;
    localparam logic [RW-1:0] LIM  = RW'(1) << (W - 1);
    localparam logic [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};

    logic [1:0][RW-1:0] n_mag;
    logic [1:0]         n_neg, n_big, n_sat;
    logic [1:0][W-1:0]  n_val;
    logic [1:0]         n_status;
    logic               r_done;
    logic [W-1:0]       r_re, r_im;
    logic [1:0]         r_status;

    // Pick the magnitude, then saturate to the output format
    always_comb begin
        n_neg[0] = i_ctl.neg_re;
        n_neg[1] = i_ctl.neg_im;
        n_big[0] = i_ctl.big_re;
        n_big[1] = i_ctl.big_im;
        for (int p = 0; p < 2; p++) begin
            if (i_ctl.div) begin
                n_mag[p] = n_big[p] ? {RW{1'b1}} : RW'(i_q[p]);
            end else begin
                n_mag[p] = i_rem[p];
            end
            if (n_neg[p]) begin
                n_sat[p] = (n_mag[p] > LIM);
                n_val[p] = n_sat[p] ? SMIN : W'(-n_mag[p]);
            end else begin
                n_sat[p] = (n_mag[p] >= LIM);
                n_val[p] = n_sat[p] ? SMAX : n_mag[p][W-1:0];
            end
        end
        if (i_ctl.dz) begin
            n_val    = '0;
            n_status = cau_pkg::ST_MATH_ERR;
        end else if (n_sat != 2'b00) begin
            n_status = cau_pkg::ST_OVERFLOW;
        end else begin
            n_status = cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
        r_re     <= n_val[0];
        r_im     <= n_val[1];
        r_status <= n_status;
    end

    assign o_done      = r_done;
    assign o_result_re = r_re;
    assign o_result_im = r_im;
    assign o_status    = r_status;

endmodule

`default_nettype wire

[rtl/core/complex_arithmetic_unit.sv]
// Channel   Handshake              Payload
// command   start & !busy          i_operation, i_left_re/im, i_right_re/im
// result    o_done (one cycle)     o_result_re, o_result_im, o_status
//
// One transaction is accepted every cycle; busy is high only during reset.
// The path runs through six front stages (operand capture,
// products, combine, sign split, rounding, division seed), a row of
// DATA_WIDTH division cells that each resolve one quotient bit, and the
// saturating output register. Every operation takes the same path.
// Reset clears the valid bits of all stages. The receiver cannot stall.
`default_nettype none

module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_operation,
    input  wire logic signed [DATA_WIDTH-1:0]  i_left_re,
    input  wire logic signed [DATA_WIDTH-1:0]  i_left_im,
    input  wire logic signed [DATA_WIDTH-1:0]  i_right_re,
    input  wire logic signed [DATA_WIDTH-1:0]  i_right_im,
    output logic                               o_done,
    output logic signed [DATA_WIDTH-1:0]       o_result_re,
    output logic signed [DATA_WIDTH-1:0]       o_result_im,
    output logic [1:0]                         o_status
);

    localparam int W   = DATA_WIDTH;
    localparam int RW  = 2 * W + 1;
    localparam int LAT = W + 7;

    logic accept;

    cau_pkg::t_ctl     c_ctl [W+1];
    logic [1:0][RW-1:0] c_rem [W+1];
    logic [1:0][W-1:0]  c_nlo [W+1];
    logic [1:0][W-1:0]  c_q   [W+1];
    logic [RW-1:0]      c_dv  [W+1];

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_operation (i_operation),
        .i_left_re   (i_left_re),
        .i_left_im   (i_left_im),
        .i_right_re  (i_right_re),
        .i_right_im  (i_right_im),
        .o_ctl       (c_ctl[0]),
        .o_rem       (c_rem[0]),
        .o_nlo       (c_nlo[0]),
        .o_dv        (c_dv[0])
    );

    assign c_q[0] = '0;

    // Division row: one quotient bit per cell
    for (genvar k = 0; k < W; k++) begin : g_cell
        cau_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .i_rem   (c_rem[k]),
            .i_nlo   (c_nlo[k]),
            .i_q     (c_q[k]),
            .i_dv    (c_dv[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_nlo   (c_nlo[k+1]),
            .o_q     (c_q[k+1]),
            .o_dv    (c_dv[k+1])
        );
    end

    cau_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (c_ctl[W]),
        .i_rem       (c_rem[W]),
        .i_q         (c_q[W]),
        .o_done      (o_done),
        .o_result_re (o_result_re),
        .o_result_im (o_result_im),
        .o_status    (o_status)
    );

    // Every accepted transaction yields a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("result missing after accepted transaction");

    // No result without a matching accepted transaction
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##LAT !o_done)
        else $error("result without transaction");

    // Divide by zero reports a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == cau_pkg::ST_MATH_ERR) |->
            (o_result_re == '0 && o_result_im == '0))
        else $error("math error with nonzero result");

    // Status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == cau_pkg::ST_OK || o_status == cau_pkg::ST_MATH_ERR ||
                    o_status == cau_pkg::ST_OVERFLOW))
        else $error("undefined status code");

endmodule

`default_nettype wire
